>>> rtl/core/assert_macros.svh
// Assertion helpers used by gmvf_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check on every rising edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> rtl/core/gmvf_pkg.sv
`default_nettype none
package gmvf_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int VALUE_BITS_DEF  = 32;
   localparam int TIME_BITS       = 32;
   localparam int INDEX_BITS      = 6;
   localparam int REQ_DATA_BITS   = 72;
   localparam int REQ_USER_BITS   = 1;
   localparam int RSP_DATA_BITS   = 40;
   localparam int RSP_USER_BITS   = 5;

   typedef enum logic [2:0] {
      KIND_ORIG   = 3'd0,
      KIND_PREV   = 3'd1,
      KIND_FIRST  = 3'd2,
      KIND_TIME   = 3'd3,
      KIND_GLOBAL = 3'd4,
      KIND_NONE   = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK          = 2'd0,
      ERR_ALL_MISSING = 2'd1,
      ERR_TOO_MANY    = 2'd2,
      ERR_OPEN_GROUP  = 2'd3
   } err_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_P1_EX,
      OP_P2_EX,
      OP_SCAN_INIT,
      OP_SCAN_EX,
      OP_DIV_START,
      OP_MEAN_WR,
      OP_NEXT_I,
      OP_GLOBAL_INIT,
      OP_EMIT_INIT,
      OP_EMIT_LD,
      OP_ERR_LD
   } op_type;

   typedef struct packed {
      logic   load_en;
      logic   rd_sel_k;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic set_done;
      logic set_err;
      logic i_last;
      logic i_zero;
      logic k_last;
      logic entry_missing;
      logic cnt_zero;
      logic div_done;
      logic out_full;
      logic global_mode;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/core/gmvf_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module gmvf_div #(
   parameter int SW = 39,
   parameter int CW = 7,
   parameter int VB = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [SW-1:0] dividend,
   input  wire logic        [CW-1:0] divisor,
   output logic                      done,
   output logic signed [VB-1:0]      quotient
);

   localparam int NW = $clog2(SW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [NW-1:0] step_ff;
   logic [CW-1:0] rem_ff;
   logic [SW-1:0] quo_ff;
   logic          neg_ff;

   logic [CW:0]   rem_sh;
   logic          ge;
   logic [CW:0]   rem_nx;
   logic [VB-1:0] qlow;

   assign rem_sh = {rem_ff, quo_ff[SW-1]};
   assign ge     = rem_sh >= {1'b0, divisor};
   assign rem_nx = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
   assign qlow   = quo_ff[VB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == NW'(SW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= '0;
         rem_ff  <= '0;
         quo_ff  <= dividend[SW-1] ? (~dividend + 1'b1) : dividend;
         neg_ff  <= dividend[SW-1];
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         rem_ff  <= rem_nx[CW-1:0];
         quo_ff  <= {quo_ff[SW-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = $signed(neg_ff ? (~qlow + 1'b1) : qlow);

endmodule
`default_nettype wire

>>> rtl/core/gmvf_dpath.sv
`default_nettype none
// Sample store, fill-pass datapath and output register.
module gmvf_dpath #(
   parameter int MAX_ENTRIES = gmvf_pkg::MAX_ENTRIES_DEF,
   parameter int VALUE_BITS  = gmvf_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire gmvf_pkg::cmd_type                    cmd,
   output gmvf_pkg::status_type                      status,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [gmvf_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  wire logic [gmvf_pkg::REQ_USER_BITS-1:0]   req_tuser,
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [gmvf_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   output logic [gmvf_pkg::RSP_USER_BITS-1:0]        rsp_tuser,
   output logic                                      rsp_tlast
);

   localparam int VB = VALUE_BITS;
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = VB + CW;
   localparam int TB = gmvf_pkg::TIME_BITS;
   localparam int IB = gmvf_pkg::INDEX_BITS;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

   // storage
   logic signed [VB-1:0]  val_mem  [MAX_ENTRIES];
   logic [TB-1:0]         time_mem [MAX_ENTRIES];
   logic                  def_mem  [MAX_ENTRIES];
   logic                  gend_mem [MAX_ENTRIES];
   gmvf_pkg::kind_type    kind_mem [MAX_ENTRIES];

   logic signed [VB-1:0]  val_q;
   logic [TB-1:0]         time_q;
   logic                  def_q;
   logic                  gend_q;
   gmvf_pkg::kind_type    kind_q;

   // control and payload registers
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic          any_def_ff, any_def_in;
   logic          last_gend_ff, last_gend_in;
   logic [CW-1:0] n_ff, n_in;
   gmvf_pkg::err_type err_ff, err_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] k_ff, k_in;
   logic signed [VB-1:0] prev_val_ff, prev_val_in;
   logic          prev_has_ff, prev_has_in;
   logic          prev_gend_ff, prev_gend_in;
   logic signed [VB-1:0] carry_val_ff, carry_val_in;
   logic          carry_has_ff, carry_has_in;
   logic [TB-1:0] t_ff, t_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] acc_cnt_ff, acc_cnt_in;
   logic          global_ff, global_in;
   logic          out_valid_ff, out_valid_in;
   logic [IB-1:0] out_index_ff, out_index_in;
   logic [31:0]   out_value_ff, out_value_in;
   gmvf_pkg::kind_type out_kind_ff, out_kind_in;
   gmvf_pkg::err_type  out_err_ff, out_err_in;
   logic          out_last_ff, out_last_in;

   // combinational
   logic                 req_acc;
   logic                 store;
   logic signed [VB-1:0] in_val;
   logic [31:0]          val_out32;
   gmvf_pkg::err_type    err_now;
   logic                 any_def_now;
   logic                 last_gend_now;
   logic                 i_last;
   logic                 k_last;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic                 wr_val_en;
   logic signed [VB-1:0] wr_val_data;
   logic                 wr_kind_en;
   gmvf_pkg::kind_type   wr_kind_data;
   logic                 div_start;
   logic                 div_done;
   logic signed [VB-1:0] div_q;
   logic                 p1_fill;
   logic                 p2_has;
   logic                 scan_hit;

   assign req_tready = cmd.load_en;
   assign req_acc    = req_tvalid && req_tready;
   assign store      = req_acc && (cnt_ff < MAX_C);

   // value in: low VALUE_BITS taken as signed; wider stores zero-extend the low 32 bits
   if (VB <= 32) begin : g_in_narrow
      assign in_val = $signed(req_tdata[VB-1:0]);
   end else begin : g_in_wide
      assign in_val = $signed({{(VB-32){1'b0}}, req_tdata[31:0]});
   end

   if (VB < 32) begin : g_out_narrow
      assign val_out32 = {{(32-VB){1'b0}}, val_q};
   end else begin : g_out_wide
      assign val_out32 = val_q[31:0];
   end

   assign any_def_now   = any_def_ff | (store & req_tdata[32]);
   assign last_gend_now = store ? req_tuser[0] : last_gend_ff;

   always_comb begin
      if (ovf_ff || !store) begin
         err_now = gmvf_pkg::ERR_TOO_MANY;
      end else if (!last_gend_now) begin
         err_now = gmvf_pkg::ERR_OPEN_GROUP;
      end else if (!any_def_now) begin
         err_now = gmvf_pkg::ERR_ALL_MISSING;
      end else begin
         err_now = gmvf_pkg::ERR_OK;
      end
   end

   assign i_last  = CW'(i_ff) == (n_ff - CW'(1));
   assign k_last  = CW'(k_ff) == (n_ff - CW'(1));
   assign wr_addr = cmd.load_en ? cnt_ff[AW-1:0] : i_ff;
   assign rd_addr = cmd.rd_sel_k ? k_ff : i_ff;

   assign p1_fill  = !def_q && (i_ff != '0) && !prev_gend_ff && prev_has_ff;
   assign p2_has   = carry_has_ff && !gend_q;
   assign scan_hit = (kind_q != gmvf_pkg::KIND_NONE) && (global_ff || time_q == t_ff);

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      any_def_in   = any_def_ff;
      last_gend_in = last_gend_ff;
      n_in         = n_ff;
      err_in       = err_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      prev_val_in  = prev_val_ff;
      prev_has_in  = prev_has_ff;
      prev_gend_in = prev_gend_ff;
      carry_val_in = carry_val_ff;
      carry_has_in = carry_has_ff;
      t_in         = t_ff;
      sum_in       = sum_ff;
      acc_cnt_in   = acc_cnt_ff;
      global_in    = global_ff;
      out_valid_in = out_valid_ff;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_kind_in  = out_kind_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      wr_val_en    = store;
      wr_val_data  = in_val;
      wr_kind_en   = 1'b0;
      wr_kind_data = kind_q;
      div_start    = 1'b0;

      if (store) begin
         cnt_in       = cnt_ff + CW'(1);
         any_def_in   = any_def_now;
         last_gend_in = req_tuser[0];
      end
      if (req_acc && !store) begin
         ovf_in = 1'b1;
      end
      // set closes: latch size and status, rearm the loader
      if (req_acc && req_tlast) begin
         n_in         = store ? (cnt_ff + CW'(1)) : cnt_ff;
         err_in       = err_now;
         cnt_in       = '0;
         ovf_in       = 1'b0;
         any_def_in   = 1'b0;
         i_in         = '0;
         carry_has_in = 1'b0;
         global_in    = 1'b0;
      end

      if (rsp_tvalid && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (cmd.op)
         gmvf_pkg::OP_P1_EX: begin
            // forward carry within a group
            wr_kind_en   = 1'b1;
            wr_kind_data = p1_fill ? gmvf_pkg::KIND_PREV
                         : (def_q ? gmvf_pkg::KIND_ORIG : gmvf_pkg::KIND_NONE);
            wr_val_en    = p1_fill;
            wr_val_data  = prev_val_ff;
            prev_val_in  = p1_fill ? prev_val_ff : val_q;
            prev_has_in  = p1_fill | def_q;
            prev_gend_in = gend_q;
            if (!i_last) begin
               i_in = i_ff + AW'(1);
            end
         end
         gmvf_pkg::OP_P2_EX: begin
            // backward walk: carry holds first value of the group
            if (kind_q == gmvf_pkg::KIND_NONE && p2_has) begin
               wr_val_en    = 1'b1;
               wr_val_data  = carry_val_ff;
               wr_kind_en   = 1'b1;
               wr_kind_data = gmvf_pkg::KIND_FIRST;
            end
            carry_has_in = (kind_q != gmvf_pkg::KIND_NONE) | p2_has;
            carry_val_in = (kind_q != gmvf_pkg::KIND_NONE) ? val_q : carry_val_ff;
            if (i_ff != '0) begin
               i_in = i_ff - AW'(1);
            end
         end
         gmvf_pkg::OP_SCAN_INIT: begin
            t_in       = time_q;
            sum_in     = '0;
            acc_cnt_in = '0;
            k_in       = '0;
         end
         gmvf_pkg::OP_SCAN_EX: begin
            if (scan_hit) begin
               sum_in     = sum_ff + SW'(val_q);
               acc_cnt_in = acc_cnt_ff + CW'(1);
            end
            if (!k_last) begin
               k_in = k_ff + AW'(1);
            end
         end
         gmvf_pkg::OP_DIV_START: begin
            div_start = 1'b1;
         end
         gmvf_pkg::OP_MEAN_WR: begin
            wr_val_en    = 1'b1;
            wr_val_data  = div_q;
            wr_kind_en   = 1'b1;
            wr_kind_data = global_ff ? gmvf_pkg::KIND_GLOBAL : gmvf_pkg::KIND_TIME;
         end
         gmvf_pkg::OP_NEXT_I: begin
            i_in = i_ff + AW'(1);
         end
         gmvf_pkg::OP_GLOBAL_INIT: begin
            i_in      = '0;
            global_in = 1'b1;
         end
         gmvf_pkg::OP_EMIT_INIT: begin
            i_in = '0;
         end
         gmvf_pkg::OP_EMIT_LD: begin
            out_valid_in = 1'b1;
            out_index_in = IB'(i_ff);
            out_value_in = val_out32;
            out_kind_in  = kind_q;
            out_err_in   = gmvf_pkg::ERR_OK;
            out_last_in  = i_last;
            if (!i_last) begin
               i_in = i_ff + AW'(1);
            end
         end
         gmvf_pkg::OP_ERR_LD: begin
            out_valid_in = 1'b1;
            out_index_in = '0;
            out_value_in = '0;
            out_kind_in  = gmvf_pkg::KIND_ORIG;
            out_err_in   = err_ff;
            out_last_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         any_def_ff   <= 1'b0;
         last_gend_ff <= 1'b0;
         global_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         any_def_ff   <= any_def_in;
         last_gend_ff <= last_gend_in;
         global_ff    <= global_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      err_ff       <= err_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      prev_val_ff  <= prev_val_in;
      prev_has_ff  <= prev_has_in;
      prev_gend_ff <= prev_gend_in;
      carry_val_ff <= carry_val_in;
      carry_has_ff <= carry_has_in;
      t_ff         <= t_in;
      sum_ff       <= sum_in;
      acc_cnt_ff   <= acc_cnt_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_kind_ff  <= out_kind_in;
      out_err_ff   <= out_err_in;
      out_last_ff  <= out_last_in;
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_val_en) begin
         val_mem[wr_addr] <= wr_val_data;
      end
      if (wr_kind_en) begin
         kind_mem[wr_addr] <= wr_kind_data;
      end
      if (store) begin
         time_mem[wr_addr] <= req_tdata[64:33];
         def_mem[wr_addr]  <= req_tdata[32];
         gend_mem[wr_addr] <= req_tuser[0];
      end
      val_q  <= val_mem[rd_addr];
      time_q <= time_mem[rd_addr];
      def_q  <= def_mem[rd_addr];
      gend_q <= gend_mem[rd_addr];
      kind_q <= kind_mem[rd_addr];
   end

   gmvf_div #(
      .SW(SW),
      .CW(CW),
      .VB(VB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (acc_cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign status.set_done      = req_acc && req_tlast;
   assign status.set_err       = err_now != gmvf_pkg::ERR_OK;
   assign status.i_last        = i_last;
   assign status.i_zero        = i_ff == '0;
   assign status.k_last        = k_last;
   assign status.entry_missing = kind_q == gmvf_pkg::KIND_NONE;
   assign status.cnt_zero      = acc_cnt_ff == '0;
   assign status.div_done      = div_done;
   assign status.out_full      = out_valid_ff;
   assign status.global_mode   = global_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_value_ff, out_index_ff};
   assign rsp_tuser  = {out_err_ff, out_kind_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

>>> rtl/core/gmvf_ctrl.sv
`default_nettype none
// Pass sequencer.
module gmvf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gmvf_pkg::status_type status,
   output gmvf_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_LOAD,
      S_ERR,
      S_P1_RD,
      S_P1_EX,
      S_P2_RD,
      S_P2_EX,
      S_P3_RD,
      S_P3_CHK,
      S_K_RD,
      S_K_EX,
      S_DIV,
      S_DIV_WAIT,
      S_NEXT,
      S_E_RD,
      S_E_LD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.load_en  = 1'b0;
      cmd.rd_sel_k = 1'b0;
      cmd.op       = gmvf_pkg::OP_NONE;
      case (state_ff)
         S_LOAD: begin
            cmd.load_en = 1'b1;
            if (status.set_done) begin
               state_in = status.set_err ? S_ERR : S_P1_RD;
            end
         end
         S_ERR: begin
            if (!status.out_full) begin
               cmd.op   = gmvf_pkg::OP_ERR_LD;
               state_in = S_LOAD;
            end
         end
         S_P1_RD: state_in = S_P1_EX;
         S_P1_EX: begin
            cmd.op   = gmvf_pkg::OP_P1_EX;
            state_in = status.i_last ? S_P2_RD : S_P1_RD;
         end
         S_P2_RD: state_in = S_P2_EX;
         S_P2_EX: begin
            cmd.op   = gmvf_pkg::OP_P2_EX;
            state_in = status.i_zero ? S_P3_RD : S_P2_RD;
         end
         S_P3_RD: state_in = S_P3_CHK;
         S_P3_CHK: begin
            cmd.op   = gmvf_pkg::OP_SCAN_INIT;
            state_in = status.entry_missing ? S_K_RD : S_NEXT;
         end
         S_K_RD: begin
            cmd.rd_sel_k = 1'b1;
            state_in     = S_K_EX;
         end
         S_K_EX: begin
            cmd.rd_sel_k = 1'b1;
            cmd.op       = gmvf_pkg::OP_SCAN_EX;
            state_in     = status.k_last ? S_DIV : S_K_RD;
         end
         S_DIV: begin
            if (status.cnt_zero) begin
               state_in = S_NEXT;
            end else begin
               cmd.op   = gmvf_pkg::OP_DIV_START;
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.op   = gmvf_pkg::OP_MEAN_WR;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (!status.i_last) begin
               cmd.op   = gmvf_pkg::OP_NEXT_I;
               state_in = S_P3_RD;
            end else if (status.global_mode) begin
               cmd.op   = gmvf_pkg::OP_EMIT_INIT;
               state_in = S_E_RD;
            end else begin
               cmd.op   = gmvf_pkg::OP_GLOBAL_INIT;
               state_in = S_P3_RD;
            end
         end
         S_E_RD: state_in = S_E_LD;
         S_E_LD: begin
            if (!status.out_full) begin
               cmd.op   = gmvf_pkg::OP_EMIT_LD;
               state_in = status.i_last ? S_LOAD : S_E_RD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/grouped_missing_value_fill_core.sv
// Load: one sample word per cycle while ready; the set closes on tlast.
// Fill: forward and first-value passes read, then process, each entry in turn. Each mean
// pass reads and checks each entry; a gap still open adds a scan of all entries, plus
// the one-bit-per-cycle divider when the scan found values. Emit: each result word is read,
// then loaded once the output register is free. An error set gives a single result word.
// Reset is synchronous, active high: clears the loader, sequencer and output valid.
`default_nettype none
module grouped_missing_value_fill_core #(
   parameter int MAX_ENTRIES = gmvf_pkg::MAX_ENTRIES_DEF,
   parameter int VALUE_BITS  = gmvf_pkg::VALUE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // samples in
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [31:0] sample_value, [32] is_defined, [64:33] time_key, [71:65] zero
   input  wire logic [gmvf_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [0] group_end
   input  wire logic [gmvf_pkg::REQ_USER_BITS-1:0] req_tuser,
   // set_end: closes the set and starts the fill
   input  wire logic                               req_tlast,
   // results out
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [5:0] entry_index, [37:6] filled_value, [39:38] zero
   output logic [gmvf_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   // [2:0] fill_kind, [4:3] error_code
   output logic [gmvf_pkg::RSP_USER_BITS-1:0]      rsp_tuser,
   // last_result
   output logic                                    rsp_tlast
);

   // Sequencer drives one command per cycle; datapath owns the sample store,
   // pass carries, the scan accumulator, the divider and the output register.
   // Passes in order: forward carry, backward first-value fill, same-time mean,
   // global mean (walks re-read the store so earlier fills count).
   gmvf_pkg::cmd_type    cmd;
   gmvf_pkg::status_type status;

   gmvf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   gmvf_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> rtl/core/gmvf_checker.sv
`default_nettype none
`include "assert_macros.svh"
module gmvf_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [gmvf_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic [gmvf_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   input wire logic                               rsp_tlast
);

   logic [gmvf_pkg::RSP_DATA_BITS+gmvf_pkg::RSP_USER_BITS:0] rsp_word;
   logic rsp_stall;
   logic err_word;
   logic err_clean;

   assign rsp_word  = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign err_word  = rsp_tvalid && (rsp_tuser[4:3] != gmvf_pkg::ERR_OK);
   assign err_clean = rsp_tlast && (rsp_tdata == '0)
                      && (rsp_tuser[2:0] == gmvf_pkg::KIND_ORIG);

   `ASSERT_CLK(a_reset_clears_out, clock, reset |=> !rsp_tvalid, "result valid after reset")

   `ASSERT_CLK_RST(a_out_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_word), "stall")

   `ASSERT_CLK_RST(a_err_word, clock, reset, err_word |-> err_clean, "malformed error word")

   `ASSERT_CLK_RST(a_busy_no_load, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready, "busy")

endmodule

bind grouped_missing_value_fill_core gmvf_checker u_gmvf_checker (.*);
`default_nettype wire

>>> bench/fill_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fill_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [gmvf_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [gmvf_pkg::REQ_USER_BITS-1:0] req_tuser,
   input  wire logic                               req_tlast,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [gmvf_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic [gmvf_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   input  wire logic                               rsp_tlast,
   output int                                      fail_count,
   output int                                      words_owed
);
   localparam int DEPTH = gmvf_pkg::MAX_ENTRIES_DEF;

   typedef struct {
      logic [5:0]         index;
      logic [31:0]        value;
      gmvf_pkg::kind_type kind;
      gmvf_pkg::err_type  err;
      logic               last;
   } fill_word_type;

   longint             sample_val [DEPTH];
   logic               sample_def [DEPTH];
   logic [31:0]        sample_time[DEPTH];
   logic               sample_gend[DEPTH];
   gmvf_pkg::kind_type sample_kind[DEPTH];
   int                 stored;
   logic               dropped;
   fill_word_type      owed_q[$];

   initial begin
      fail_count = 0;
      words_owed = 0;
      stored = 0;
      dropped = 0;
   end

   // Runs the four fill passes over the stored set and queues the results.
   task automatic fill_set();
      int n, s, e, j;
      longint sum, cnt;
      logic any_def;
      gmvf_pkg::err_type err;
      fill_word_type w;
      n = stored;
      any_def = 0;
      for (int i = 0; i < n; i++) if (sample_def[i]) any_def = 1;
      if (dropped) err = gmvf_pkg::ERR_TOO_MANY;
      else if (!sample_gend[n-1]) err = gmvf_pkg::ERR_OPEN_GROUP;
      else if (!any_def) err = gmvf_pkg::ERR_ALL_MISSING;
      else err = gmvf_pkg::ERR_OK;
      stored = 0;
      dropped = 0;
      if (err != gmvf_pkg::ERR_OK) begin
         w = '{6'd0, 32'd0, gmvf_pkg::KIND_ORIG, err, 1'b1};
         owed_q.push_back(w);
         return;
      end
      for (int i = 0; i < n; i++) begin
         sample_kind[i] = sample_def[i] ? gmvf_pkg::KIND_ORIG : gmvf_pkg::KIND_NONE;
      end
      // forward carry inside a group
      for (int i = 1; i < n; i++) begin
         if (!sample_gend[i-1] && sample_kind[i] == gmvf_pkg::KIND_NONE
             && sample_kind[i-1] != gmvf_pkg::KIND_NONE) begin
            sample_val[i] = sample_val[i-1];
            sample_kind[i] = gmvf_pkg::KIND_PREV;
         end
      end
      // leading gaps of each group
      s = 0;
      while (s < n) begin
         e = s;
         while (e < n - 1 && !sample_gend[e]) e++;
         if (sample_kind[s] == gmvf_pkg::KIND_NONE) begin
            j = s + 1;
            while (j <= e && sample_kind[j] == gmvf_pkg::KIND_NONE) j++;
            if (j <= e) begin
               for (int k = s; k < j; k++) begin
                  sample_val[k] = sample_val[j];
                  sample_kind[k] = gmvf_pkg::KIND_FIRST;
               end
            end
         end
         s = e + 1;
      end
      // same-time mean
      for (int i = 0; i < n; i++) begin
         if (sample_kind[i] != gmvf_pkg::KIND_NONE) continue;
         sum = 0;
         cnt = 0;
         for (int k = 0; k < n; k++) begin
            if (sample_kind[k] != gmvf_pkg::KIND_NONE
                && sample_time[k] == sample_time[i]) begin
               sum += sample_val[k];
               cnt++;
            end
         end
         if (cnt != 0) begin
            sample_val[i] = sum / cnt;
            sample_kind[i] = gmvf_pkg::KIND_TIME;
         end
      end
      // global mean
      for (int i = 0; i < n; i++) begin
         if (sample_kind[i] != gmvf_pkg::KIND_NONE) continue;
         sum = 0;
         cnt = 0;
         for (int k = 0; k < n; k++) begin
            if (sample_kind[k] != gmvf_pkg::KIND_NONE) begin
               sum += sample_val[k];
               cnt++;
            end
         end
         sample_val[i] = (cnt != 0) ? sum / cnt : 0;
         sample_kind[i] = gmvf_pkg::KIND_GLOBAL;
      end
      for (int i = 0; i < n; i++) begin
         w = '{i[5:0], sample_val[i][31:0], sample_kind[i], gmvf_pkg::ERR_OK, i == n - 1};
         owed_q.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      fill_word_type w;
      if (!reset && req_tvalid && req_tready) begin
         if (stored < DEPTH) begin
            sample_val[stored]  = longint'($signed(req_tdata[31:0]));
            sample_def[stored]  = req_tdata[32];
            sample_time[stored] = req_tdata[64:33];
            sample_gend[stored] = req_tuser[0];
            stored++;
         end else begin
            dropped = 1;
         end
         if (req_tlast) fill_set();
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected word idx=%0d val=%h kind=%0d err=%0d last=%b", $time,
                     rsp_tdata[5:0], rsp_tdata[37:6], rsp_tuser[2:0], rsp_tuser[4:3],
                     rsp_tlast);
            fail_count++;
         end else begin
            w = owed_q.pop_front();
            if (rsp_tdata[5:0] !== w.index || rsp_tdata[37:6] !== w.value
                || rsp_tuser[2:0] !== w.kind || rsp_tuser[4:3] !== w.err
                || rsp_tlast !== w.last) begin
               $display("%0t: mismatch exp idx=%0d val=%h kind=%0d err=%0d last=%b",
                        $time, w.index, w.value, w.kind, w.err, w.last);
               $display("%0t:          got idx=%0d val=%h kind=%0d err=%0d last=%b",
                        $time, rsp_tdata[5:0], rsp_tdata[37:6], rsp_tuser[2:0],
                        rsp_tuser[4:3], rsp_tlast);
               fail_count++;
            end
         end
      end
      words_owed = owed_q.size();
   end
endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   localparam longint CYCLE_LIMIT = 3000000;

   logic                               clock = 0;
   logic                               reset = 1;
   logic                               req_tvalid = 0;
   logic                               req_tready;
   logic [gmvf_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;   // value, defined, time key, pad
   logic [gmvf_pkg::REQ_USER_BITS-1:0] req_tuser = '0;   // group_end
   logic                               req_tlast = 0;    // set_end
   logic                               rsp_tvalid;
   logic                               rsp_tready = 0;
   logic [gmvf_pkg::RSP_DATA_BITS-1:0] rsp_tdata;        // entry_index, filled_value, pad
   logic [gmvf_pkg::RSP_USER_BITS-1:0] rsp_tuser;        // fill_kind, error_code
   logic                               rsp_tlast;        // last_result
   int                                 fail_count;
   int                                 words_owed;
   longint                             cycles = 0;
   int                                 burst_left = 0;
   int                                 items_sent = 0;

   always #6 clock = ~clock;

   grouped_missing_value_fill_core uut (.*);

   fill_checker chk (.*);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: long runs of full ready, random stalls, and long stalls
   always @(negedge clock) begin
      case ((cycles / 500) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 1) != 0);
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // one sample word; gaps fall between bursts
   task automatic send_word(input logic [31:0] value, input logic defined,
                            input logic [31:0] tkey, input logic gend, input logic send);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid = 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tdata = {7'd0, tkey, defined, value};
      req_tuser = gend;
      req_tlast = send;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 255) << 16;
         default: return $urandom();
      endcase
   endfunction

   // mode: 0 normal, 1 all missing, 2 open final group
   task automatic random_set(input int n, input int mode, input int miss_pct,
                             input logic wide_keys);
      logic gend, defined;
      logic [31:0] tkey;
      for (int i = 0; i < n; i++) begin
         defined = (mode == 1) ? 1'b0 : ($urandom_range(0, 99) >= miss_pct);
         tkey = wide_keys ? $urandom() : $urandom_range(0, 3);
         gend = ($urandom_range(0, 3) == 0);
         if (i == n - 1) gend = (mode != 2);
         send_word(pick_value(), defined, tkey, gend, i == n - 1);
      end
   endtask

   initial begin
      int n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: single extreme entry, every fill kind, and each error
      send_word(32'h7fff_ffff, 1, 32'hffff_ffff, 1, 1);
      // carry forward, then a group with leading gaps, then a lone gap
      send_word(32'h8000_0000, 1, 5, 0, 0);
      send_word(32'd0, 0, 6, 0, 0);
      send_word(32'd0, 0, 7, 1, 0);
      send_word(32'd0, 0, 5, 0, 0);
      send_word(32'h0003_0000, 1, 9, 1, 0);
      send_word(32'd0, 0, 5, 1, 0);      // same-time mean (negative truncation)
      send_word(32'd0, 0, 42, 1, 1);     // global mean
      // all missing
      send_word(32'h1234_5678, 0, 0, 0, 0);
      send_word(32'h1234_5678, 0, 0, 1, 1);
      // final group left open
      send_word(32'hffff_ffff, 1, 0, 1, 0);
      send_word(32'h0000_0001, 1, 0, 0, 1);
      // no gaps at all
      send_word(32'hffff_fffd, 1, 1, 0, 0);
      send_word(32'h0000_0002, 1, 2, 1, 1);
      // too many samples, open final group too
      random_set(gmvf_pkg::MAX_ENTRIES_DEF + 2, 2, 30, 0);

      // random sets, mostly small
      while (items_sent < 180) begin
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 10);
         case ($urandom_range(0, 9))
            0: random_set(n, 1, 0, 0);
            1: random_set(n, 2, 40, 1);
            2: random_set(n, 0, 0, 1);
            3: random_set(n, 0, 85, 0);
            default: random_set(n, 0, $urandom_range(20, 70), $urandom_range(0, 3) == 0);
         endcase
      end
      @(negedge clock);
      req_tvalid = 0;

      wait (words_owed == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && !rsp_tvalid) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
